// ===== rtl/dlt_pkg.sv =====
// ---------------------------------------------------------------------------
// dlt_pkg: shared types and constants of the DHCP lease table
// Item and result layouts, config register codes, lease table sizing.
// ---------------------------------------------------------------------------
`default_nettype none

package dlt_pkg;

  localparam int CLIENT_COUNT = 8;
  localparam int IDX_W        = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
  localparam int MAC_W        = 48;
  localparam int EXP_W        = 16;
  localparam int SLOT_W       = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [7:0] CLIENT_COUNT_B = 8'(CLIENT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENT_COUNT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERVER_ADDRESS = 2'd0,
    CFG_BASE_HOST      = 2'd1,
    CFG_LEASE_MS       = 2'd2
  } dlt_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OFFER        = 3'd0,
    ST_ACK          = 3'd1,
    ST_NO_FREE      = 3'd2,
    ST_NO_REQUESTED = 3'd3,
    ST_WRONG_SUBNET = 3'd4,
    ST_OUT_OF_RANGE = 3'd5,
    ST_IN_USE       = 3'd6
  } dlt_status_e;

  typedef struct packed {
    logic             req_type;
    logic [MAC_W-1:0] client_mac;
    logic             requested_present;
    logic [31:0]      requested_address;
    logic [31:0]      now_ms;
  } dlt_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [31:0]       assigned_address;
    logic [SLOT_W-1:0] slot_index;
  } dlt_result_t;

  typedef struct packed {
    logic [31:0] server_address;
    logic [7:0]  base_host;
    logic [31:0] lease_ms;
  } dlt_cfg_t;

  // lease table write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [MAC_W-1:0] owner;
    logic             set_expiry;
    logic [EXP_W-1:0] expiry;
  } dlt_wr_t;

endpackage

`default_nettype wire

// ===== rtl/dlt_alu.sv =====
// ---------------------------------------------------------------------------
// dlt_alu: shared 32-bit add/subtract unit
// Used for the expiry test, the slot offset and the new expiry time.
// ---------------------------------------------------------------------------
`default_nettype none

module dlt_alu
  import dlt_pkg::*;
(
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sub_i,
  output logic [31:0] res_o
);

  assign res_o = sub_i ? (a_i - b_i) : (a_i + b_i);

endmodule

`default_nettype wire

// ===== rtl/dlt_table.sv =====
// ---------------------------------------------------------------------------
// dlt_table: lease slot storage
// Owner MAC and coarse expiry per slot, cleared at reset, one read port.
// ---------------------------------------------------------------------------
`default_nettype none

module dlt_table
  import dlt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_idx_i,
  input  dlt_wr_t          wr_i,
  output logic [MAC_W-1:0] rd_owner_o,
  output logic [EXP_W-1:0] rd_expiry_o
);

  logic [MAC_W-1:0] owner_q  [CLIENT_COUNT];
  logic [EXP_W-1:0] expiry_q [CLIENT_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CLIENT_COUNT; i++) begin
        owner_q[i]  <= '0;
        expiry_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      owner_q[wr_i.idx] <= wr_i.owner;
      if (wr_i.set_expiry) begin
        expiry_q[wr_i.idx] <= wr_i.expiry;
      end
    end
  end

  assign rd_owner_o  = owner_q[rd_idx_i];
  assign rd_expiry_o = expiry_q[rd_idx_i];

endmodule

`default_nettype wire

// ===== rtl/dlt_ctrl.sv =====
// ---------------------------------------------------------------------------
// dlt_ctrl: lease sequencer
// Scans slots for a discover, checks and claims a slot for a request.
// ---------------------------------------------------------------------------
`default_nettype none

module dlt_ctrl
  import dlt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dlt_item_t        item_i,
  input  dlt_cfg_t         cfg_i,
  input  logic [MAC_W-1:0] rd_owner_i,
  input  logic [EXP_W-1:0] rd_expiry_i,
  input  logic [31:0]      alu_res_i,
  output logic [IDX_W-1:0] rd_idx_o,
  output dlt_wr_t          wr_o,
  output logic [31:0]      alu_a_o,
  output logic [31:0]      alu_b_o,
  output logic             alu_sub_o,
  output logic             busy_o,
  output logic             done_o,
  output dlt_result_t      result_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_RANGE = 5'b01000,
    S_CLAIM = 5'b10000
  } dlt_state_e;

  dlt_state_e       state_q, state_d;
  dlt_item_t        item_q, item_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [7:0]       slot_q, slot_d;
  logic             done_q, done_d;
  dlt_result_t      result_q, result_d;

  logic             owner_zero;
  logic             mac_hit;
  logic             nf_found;
  logic [IDX_W-1:0] nf_idx;

  function automatic dlt_result_t mk_result(dlt_status_e st, logic [IDX_W-1:0] slot,
                                            dlt_cfg_t cfg);
    dlt_result_t r;
    r.status           = st;
    r.assigned_address = {cfg.server_address[31:8], cfg.base_host + 8'(slot)};
    r.slot_index       = SLOT_W'(slot);
    return r;
  endfunction

  function automatic dlt_result_t mk_error(dlt_status_e st);
    dlt_result_t r;
    r.status           = st;
    r.assigned_address = '0;
    r.slot_index       = '0;
    return r;
  endfunction

  assign owner_zero = (rd_owner_i == '0);
  assign mac_hit    = (rd_owner_i == item_q.client_mac);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    idx_d        = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    slot_d       = slot_q;
    done_d       = 1'b0;
    result_d     = result_q;
    rd_idx_o     = idx_q;
    wr_o         = '0;
    alu_a_o      = '0;
    alu_b_o      = '0;
    alu_sub_o    = 1'b1;
    nf_found     = free_found_q;
    nf_idx       = free_idx_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d       = item_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          state_d      = item_i.req_type ? S_CHECK : S_SCAN;
        end
      end

      S_SCAN: begin
        // expired when {expiry, ffff} - now is negative
        alu_a_o = {rd_expiry_i, 16'hffff};
        alu_b_o = item_q.now_ms;
        if (mac_hit) begin
          done_d   = 1'b1;
          result_d = mk_result(ST_OFFER, idx_q, cfg_i);
          state_d  = S_IDLE;
        end else begin
          if (!free_found_q && (owner_zero || alu_res_i[31])) begin
            nf_found = 1'b1;
            nf_idx   = idx_q;
            if (!owner_zero) begin
              wr_o.en    = 1'b1;
              wr_o.idx   = idx_q;
              wr_o.owner = '0;
            end
          end
          free_found_d = nf_found;
          free_idx_d   = nf_idx;
          if (idx_q == LAST_IDX) begin
            done_d   = 1'b1;
            result_d = nf_found ? mk_result(ST_OFFER, nf_idx, cfg_i) : mk_error(ST_NO_FREE);
            state_d  = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      S_CHECK: begin
        alu_a_o = {24'd0, item_q.requested_address[7:0]};
        alu_b_o = {24'd0, cfg_i.base_host};
        if (!item_q.requested_present) begin
          done_d   = 1'b1;
          result_d = mk_error(ST_NO_REQUESTED);
          state_d  = S_IDLE;
        end else if (item_q.requested_address[31:8] != cfg_i.server_address[31:8]) begin
          done_d   = 1'b1;
          result_d = mk_error(ST_WRONG_SUBNET);
          state_d  = S_IDLE;
        end else begin
          slot_d  = alu_res_i[7:0];
          state_d = S_RANGE;
        end
      end

      S_RANGE: begin
        rd_idx_o = slot_q[IDX_W-1:0];
        if (slot_q >= CLIENT_COUNT_B) begin
          done_d   = 1'b1;
          result_d = mk_error(ST_OUT_OF_RANGE);
          state_d  = S_IDLE;
        end else if (!mac_hit && !owner_zero) begin
          done_d   = 1'b1;
          result_d = mk_error(ST_IN_USE);
          state_d  = S_IDLE;
        end else begin
          state_d = S_CLAIM;
        end
      end

      S_CLAIM: begin
        rd_idx_o        = slot_q[IDX_W-1:0];
        alu_a_o         = item_q.now_ms;
        alu_b_o         = cfg_i.lease_ms;
        alu_sub_o       = 1'b0;
        wr_o.en         = 1'b1;
        wr_o.idx        = slot_q[IDX_W-1:0];
        wr_o.owner      = item_q.client_mac;
        wr_o.set_expiry = 1'b1;
        wr_o.expiry     = alu_res_i[31:16];
        done_d          = 1'b1;
        result_d        = mk_result(ST_ACK, slot_q[IDX_W-1:0], cfg_i);
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    slot_q   <= slot_d;
    result_q <= result_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== rtl/dhcp_lease_table_top.sv =====
// ---------------------------------------------------------------------------
// dhcp_lease_table_top: DHCP server lease allocation core
// Lease table of client MACs with coarse expiry; answers discover/request.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  item in  | start_i & !busy_o     | item_i   (dlt_item_t)
//  result   | done_o, one cycle     | result_o (dlt_result_t)
//  config   | cfg_we_i              | cfg_idx_i, cfg_data_i
//
//  Discover: scans the slots in turn, stops on a MAC hit, at most
//  CLIENT_COUNT slots; serial due to the single read port and shared adder.
//  Request: S_CHECK then S_RANGE, each may end on an error, then S_CLAIM.
//  Result strobes the cycle after the last step; busy_o drops in that cycle.
//  Reset clears every lease slot at once; no clearing pass.
//  The result side has no back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module dhcp_lease_table_top
  import dlt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  dlt_item_t             item_i,
  output logic                  busy_o,
  output logic                  done_o,
  output dlt_result_t           result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dlt_cfg_t         cfg_q;
  logic [IDX_W-1:0] rd_idx;
  dlt_wr_t          wr;
  logic [MAC_W-1:0] rd_owner;
  logic [EXP_W-1:0] rd_expiry;
  logic [31:0]      alu_a;
  logic [31:0]      alu_b;
  logic             alu_sub;
  logic [31:0]      alu_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.server_address <= 32'd0;
      cfg_q.base_host      <= 8'd16;
      cfg_q.lease_ms       <= 32'd43200000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SERVER_ADDRESS: cfg_q.server_address <= cfg_data_i;
        CFG_BASE_HOST:      cfg_q.base_host      <= cfg_data_i[7:0];
        CFG_LEASE_MS:       cfg_q.lease_ms       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .cfg_i       (cfg_q),
    .rd_owner_i  (rd_owner),
    .rd_expiry_i (rd_expiry),
    .alu_res_i   (alu_res),
    .rd_idx_o    (rd_idx),
    .wr_o        (wr),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_sub_o   (alu_sub),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  dlt_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_idx_i    (rd_idx),
    .wr_i        (wr),
    .rd_owner_o  (rd_owner),
    .rd_expiry_o (rd_expiry)
  );

  dlt_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res)
  );

endmodule

`default_nettype wire

// ===== rtl/dlt_chk.sv =====
// ---------------------------------------------------------------------------
// dlt_chk: port-level checker for the DHCP lease table
// Watches item/result sequencing and result encoding on the top ports.
// ---------------------------------------------------------------------------
`default_nettype none

module dlt_chk
  import dlt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input dlt_result_t result_o
);

  a_busy_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after item accepted");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status <= ST_IN_USE))
    else $error("illegal status code");

  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OFFER && result_o.status != ST_ACK)
      |-> (result_o.assigned_address == '0 && result_o.slot_index == '0))
    else $error("error result carries an address");

endmodule

bind dhcp_lease_table_top dlt_chk u_dlt_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
